[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication: when the trigger holds, the consequence holds in the same cycle.
`define ASSERT_IMPL(label, clk, rst_n, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) else $error(msg);

`endif

[rtl/hcih4_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package hcih4_pkg;

    localparam logic [7:0] TYPE_CMD = 8'h01;
    localparam logic [7:0] TYPE_ACL = 8'h02;

    localparam int unsigned L2CAP_MTU = 64;
    localparam logic [7:0]  CMD_MAX_RESET = 8'd255;
    localparam logic [15:0] ACL_MAX_RESET = 16'(L2CAP_MTU + 4);

    localparam logic [1:0] PH_TYPE    = 2'd0;
    localparam logic [1:0] PH_HEADER  = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;
    localparam logic [1:0] PH_DISCARD = 2'd3;

    localparam logic [1:0] ROLE_TYPE    = 2'd0;
    localparam logic [1:0] ROLE_HEADER  = 2'd1;
    localparam logic [1:0] ROLE_PAYLOAD = 2'd2;
    localparam logic [1:0] ROLE_DISCARD = 2'd3;

    localparam logic KIND_CMD = 1'b0;
    localparam logic KIND_ACL = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_UNKNOWN   = 2'd1;
    localparam logic [1:0] ST_OVERLIMIT = 2'd2;

    localparam logic [1:0] HDR_LEN_POS  = 2'd2;
    localparam logic [1:0] HDR_LAST_CMD = 2'd2;
    localparam logic [1:0] HDR_LAST_ACL = 2'd3;

    localparam logic REG_CMD_MAX = 1'b0;
    localparam logic REG_ACL_MAX = 1'b1;

    typedef struct packed {
        logic [15:0] acl_max_payload;
        logic [7:0]  cmd_max_params;
    } t_cfg;

    typedef struct packed {
        logic [1:0] status;
        logic       packet_end;
        logic       packet_kind;
        logic [1:0] byte_role;
        logic [7:0] out_byte;
    } t_result;

    typedef struct packed {
        logic [1:0] phase;
        logic       left_zero;
    } t_fsm_status;

endpackage

`default_nettype wire

[rtl/hcih4_cfg.sv]
`timescale 1ns / 1ps
`default_nettype none

module hcih4_cfg
    import hcih4_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output t_cfg             o_cfg
);

    logic [7:0]  r_cmd_max;
    logic [15:0] r_acl_max;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_max <= CMD_MAX_RESET;
            r_acl_max <= ACL_MAX_RESET;
        end else if (wr_en) begin
            case (paddr[2])
                REG_CMD_MAX: r_cmd_max <= pwdata[7:0];
                REG_ACL_MAX: r_acl_max <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_CMD_MAX: prdata = {24'd0, r_cmd_max};
            REG_ACL_MAX: prdata = {16'd0, r_acl_max};
            default:     prdata = 32'd0;
        endcase
    end

    assign o_cfg.cmd_max_params  = r_cmd_max;
    assign o_cfg.acl_max_payload = r_acl_max;

endmodule

`default_nettype wire

[rtl/hcih4_fsm.sv]
`timescale 1ns / 1ps
`default_nettype none

module hcih4_fsm
    import hcih4_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cfg       i_cfg,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_in_byte,
    output logic            o_res_valid,
    input  wire logic       i_res_ready,
    output t_result         o_res,
    output t_fsm_status     o_status
);

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic [1:0]  r_phase,    n_phase;
    logic        r_kind,     n_kind;
    logic [1:0]  r_hpos,     n_hpos;
    logic [7:0]  r_len_low,  n_len_low;
    logic [15:0] r_left,     n_left;
    logic        fire;
    logic [1:0]  last_pos;
    logic [15:0] len;
    logic [15:0] limit;

    assign fire        = r_in_valid && i_res_ready;
    assign o_in_ready  = !r_in_valid || i_res_ready;
    assign o_res_valid = r_in_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_in_byte;
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_kind    = r_kind;
        n_hpos    = r_hpos;
        n_len_low = r_len_low;
        n_left    = r_left;
        last_pos  = r_kind ? HDR_LAST_ACL : HDR_LAST_CMD;
        len       = r_kind ? {r_in_byte, r_len_low} : {8'd0, r_in_byte};
        limit     = r_kind ? i_cfg.acl_max_payload : {8'd0, i_cfg.cmd_max_params};
        o_res.out_byte    = r_in_byte;
        o_res.byte_role   = ROLE_TYPE;
        o_res.packet_kind = r_kind;
        o_res.packet_end  = 1'b0;
        o_res.status      = ST_OK;
        case (r_phase)
            PH_TYPE: begin
                if (r_in_byte == TYPE_CMD || r_in_byte == TYPE_ACL) begin
                    n_kind    = (r_in_byte == TYPE_ACL) ? KIND_ACL : KIND_CMD;
                    n_hpos    = 2'd0;
                    n_len_low = 8'd0;
                    n_left    = 16'd0;
                    n_phase   = PH_HEADER;
                    o_res.packet_kind = n_kind;
                end else begin
                    o_res.packet_kind = KIND_CMD;
                    o_res.status      = ST_UNKNOWN;
                end
            end
            PH_HEADER: begin
                o_res.byte_role = ROLE_HEADER;
                if (r_hpos < last_pos) begin
                    if (r_hpos == HDR_LEN_POS) begin
                        n_len_low = r_in_byte;
                    end
                    n_hpos = r_hpos + 2'd1;
                end else begin
                    n_hpos = 2'd0;
                    n_left = len;
                    if (len == 16'd0) begin
                        n_phase = PH_TYPE;
                        o_res.packet_end = 1'b1;
                    end else if (len > limit) begin
                        n_phase = PH_DISCARD;
                        o_res.status = ST_OVERLIMIT;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end
            end
            default: begin
                o_res.byte_role = (r_phase == PH_DISCARD) ? ROLE_DISCARD : ROLE_PAYLOAD;
                if (r_left <= 16'd1) begin
                    n_left  = 16'd0;
                    n_phase = PH_TYPE;
                    o_res.packet_end = 1'b1;
                end else begin
                    n_left = r_left - 16'd1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_TYPE;
            r_kind    <= KIND_CMD;
            r_hpos    <= 2'd0;
            r_len_low <= 8'd0;
            r_left    <= 16'd0;
        end else if (fire) begin
            r_phase   <= n_phase;
            r_kind    <= n_kind;
            r_hpos    <= n_hpos;
            r_len_low <= n_len_low;
            r_left    <= n_left;
        end
    end

    assign o_status.phase     = r_phase;
    assign o_status.left_zero = (r_left == 16'd0);

endmodule

`default_nettype wire

[rtl/hcih4_out.sv]
`timescale 1ns / 1ps
`default_nettype none

module hcih4_out
    import hcih4_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_ready,
    input  wire t_result i_res,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_result      o_res
);

    logic    r_main_valid;
    logic    r_skid_valid;
    t_result r_main;
    t_result r_skid;
    logic    take;
    logic    load_main;

    assign o_ready   = !r_skid_valid;
    assign take      = i_valid && !r_skid_valid;
    assign load_main = !r_main_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (load_main) begin
            r_main_valid <= r_skid_valid || take;
            r_skid_valid <= 1'b0;
        end else if (take) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_main) begin
            r_main <= r_skid_valid ? r_skid : i_res;
        end else if (take) begin
            r_skid <= i_res;
        end
    end

    assign o_valid = r_main_valid;
    assign o_res   = r_main;

endmodule

`default_nettype wire

[rtl/hci_h4_uart_deframer_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// H:4 UART receive deframer.
// Input stream: one received UART byte per request on s_axis_tdata.
// Output stream: each byte passed through on m_axis_tdata, tagged in
// m_axis_tuser with its role (type, header, payload, discarded), the packet
// kind (command or ACL) and a status (ok, unknown type dropped, length over
// limit); m_axis_tlast marks the byte that completes a packet.
// APB port: register 0 at address 0 is the command parameter limit, register
// 1 at address 4 the ACL length limit; write only while the streams are idle.
// Path: a byte accepted on the input is held in the input register, goes
// through the phase update and is registered in the output buffer.
// Throughput: one byte per cycle while the output side takes bytes, set by
// the combinational phase update between the input and output registers.
// Reset: the block waits for a type byte, both limits return to their
// defaults (255 and 68) and both register stages empty.
// Output stall: a two-entry output buffer keeps tready on the input side
// registered; once it fills, s_axis_tready drops and bytes hold upstream.
`include "assert_macros.svh"

module hci_h4_uart_deframer_top
    import hcih4_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [7:0] out_byte
    output logic [4:0]       m_axis_tuser,   // [1:0] byte_role, [2] packet_kind, [4:3] status
    output logic             m_axis_tlast    // packet_end
);

    t_cfg        cfg;
    t_result     fsm_res;
    t_result     out_res;
    t_fsm_status fsm_status;
    logic        fsm_valid;
    logic        out_ready;

    hcih4_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    hcih4_fsm u_fsm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_in_byte   (s_axis_tdata),
        .o_res_valid (fsm_valid),
        .i_res_ready (out_ready),
        .o_res       (fsm_res),
        .o_status    (fsm_status)
    );

    hcih4_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fsm_valid),
        .o_ready (out_ready),
        .i_res   (fsm_res),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (out_res)
    );

    assign m_axis_tdata = out_res.out_byte;
    assign m_axis_tuser = {out_res.status, out_res.packet_kind, out_res.byte_role};
    assign m_axis_tlast = out_res.packet_end;

    `ASSERT_IMPL(a_payload_has_bytes, i_clk, i_rst_n,
        (fsm_status.phase == PH_PAYLOAD || fsm_status.phase == PH_DISCARD),
        !fsm_status.left_zero, "payload phase with no bytes left")

    `ASSERT_IMPL(a_overlimit_on_header, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tuser[4:3] == ST_OVERLIMIT,
        m_axis_tuser[1:0] == ROLE_HEADER && !m_axis_tlast, "over-limit flag off last header byte")

    `ASSERT_IMPL(a_type_never_last, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tuser[1:0] == ROLE_TYPE,
        !m_axis_tlast, "type byte marked as packet end")

    `ASSERT_IMPL(a_unknown_is_type, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tuser[4:3] == ST_UNKNOWN,
        m_axis_tuser[1:0] == ROLE_TYPE && !m_axis_tuser[2], "unknown status off a type byte")

endmodule

`default_nettype wire

[tb/tb_hci_h4_uart_deframer_top.sv]
`timescale 1ns / 1ps

module tb_hci_h4_uart_deframer_top;
    import hcih4_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TX_SIDE = 0;
    localparam int RX_SIDE = 1;
    localparam logic [2:0] ADDR_CMD_MAX = {REG_CMD_MAX, 2'b00};
    localparam logic [2:0] ADDR_ACL_MAX = {REG_ACL_MAX, 2'b00};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic [4:0]  m_axis_tuser;
    logic        m_axis_tlast;

    t_result     pending_results[$];
    logic [1:0]  rx_phase = PH_TYPE;
    logic        pkt_kind = KIND_CMD;
    logic [1:0]  hdr_pos = '0;
    logic [7:0]  len_low = '0;
    logic [15:0] left_count = '0;
    logic [7:0]  cmd_limit = CMD_MAX_RESET;
    logic [15:0] acl_limit = ACL_MAX_RESET;

    int mismatches = 0;
    int items_sent = 0;
    int idle_cycles = 0;
    int rx_hold = 0;
    int calm_cnt[2] = '{0, 0};

    hci_h4_uart_deframer_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int pick_gap(input int side);
        int r;
        if (calm_cnt[side] > 0) begin
            calm_cnt[side] = calm_cnt[side] - 1;
            return 0;
        end
        r = $urandom_range(0, 199);
        if (r < 2) begin
            calm_cnt[side] = $urandom_range(20, 80);
            return 0;
        end
        if (r < 120) return 0;
        if (r < 185) return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    function automatic t_result deframe_byte(input logic [7:0] b);
        t_result     r;
        logic [1:0]  last_pos;
        logic [15:0] len;
        logic [15:0] lim;
        r.out_byte    = b;
        r.byte_role   = ROLE_TYPE;
        r.packet_kind = KIND_CMD;
        r.packet_end  = 1'b0;
        r.status      = ST_OK;
        case (rx_phase)
            PH_TYPE: begin
                if (b == TYPE_CMD || b == TYPE_ACL) begin
                    pkt_kind      = (b == TYPE_ACL) ? KIND_ACL : KIND_CMD;
                    hdr_pos       = '0;
                    len_low       = '0;
                    left_count    = '0;
                    rx_phase      = PH_HEADER;
                    r.packet_kind = pkt_kind;
                end else begin
                    r.status = ST_UNKNOWN;
                end
            end
            PH_HEADER: begin
                r.byte_role   = ROLE_HEADER;
                r.packet_kind = pkt_kind;
                last_pos = (pkt_kind == KIND_ACL) ? HDR_LAST_ACL : HDR_LAST_CMD;
                if (hdr_pos < last_pos) begin
                    if (hdr_pos == HDR_LEN_POS) len_low = b;
                    hdr_pos = hdr_pos + 2'd1;
                end else begin
                    len = (pkt_kind == KIND_ACL) ? {b, len_low} : {8'h00, b};
                    lim = (pkt_kind == KIND_ACL) ? acl_limit : {8'h00, cmd_limit};
                    hdr_pos    = '0;
                    left_count = len;
                    if (left_count == 16'd0) begin
                        rx_phase     = PH_TYPE;
                        r.packet_end = 1'b1;
                    end else if (left_count > lim) begin
                        rx_phase = PH_DISCARD;
                        r.status = ST_OVERLIMIT;
                    end else begin
                        rx_phase = PH_PAYLOAD;
                    end
                end
            end
            default: begin
                r.byte_role   = (rx_phase == PH_DISCARD) ? ROLE_DISCARD : ROLE_PAYLOAD;
                r.packet_kind = pkt_kind;
                if (left_count <= 16'd1) begin
                    left_count   = '0;
                    r.packet_end = 1'b1;
                    rx_phase     = PH_TYPE;
                end else begin
                    left_count = left_count - 16'd1;
                end
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("%0t ns: %s got %h want %h", $realtime, field, got, want);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        if (rx_hold > 0) begin
            m_axis_tready <= 1'b0;
            rx_hold = rx_hold - 1;
        end else begin
            m_axis_tready <= 1'b1;
            rx_hold = pick_gap(RX_SIDE);
        end
    end

    always @(posedge i_clk) begin : scoreboard
        t_result want;
        logic    busy;
        busy = 1'b0;
        if (i_rst_n) begin
            if (m_axis_tvalid === 1'b1 && m_axis_tready) begin
                busy = 1'b1;
                if (pending_results.size() == 0) begin
                    report_mismatch("result with no request", 16'(m_axis_tdata), 16'h0);
                end else begin
                    want = pending_results.pop_front();
                    if (m_axis_tdata !== want.out_byte)
                        report_mismatch("out_byte", 16'(m_axis_tdata),
                                        16'(want.out_byte));
                    if (m_axis_tuser[1:0] !== want.byte_role)
                        report_mismatch("byte_role", 16'(m_axis_tuser[1:0]),
                                        16'(want.byte_role));
                    if (m_axis_tuser[2] !== want.packet_kind)
                        report_mismatch("packet_kind", 16'(m_axis_tuser[2]),
                                        16'(want.packet_kind));
                    if (m_axis_tuser[4:3] !== want.status)
                        report_mismatch("status", 16'(m_axis_tuser[4:3]),
                                        16'(want.status));
                    if (m_axis_tlast !== want.packet_end)
                        report_mismatch("packet_end", 16'(m_axis_tlast),
                                        16'(want.packet_end));
                end
            end
            if (s_axis_tvalid && s_axis_tready === 1'b1) begin
                busy = 1'b1;
                pending_results.push_back(deframe_byte(s_axis_tdata));
            end
            if (psel && penable) busy = 1'b1;
        end
        if (busy) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        items_sent++;
        gap = pick_gap(TX_SIDE);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_cmd(input int len);
        logic [7:0] len_byte;
        len_byte = len[7:0];
        send_byte(TYPE_CMD);
        send_byte(8'($urandom));
        send_byte(8'($urandom));
        send_byte(len_byte);
        repeat (len) send_byte(8'($urandom));
    endtask

    task automatic send_acl(input int len);
        logic [15:0] len_word;
        len_word = len[15:0];
        send_byte(TYPE_ACL);
        send_byte(8'($urandom));
        send_byte(8'($urandom));
        send_byte(len_word[7:0]);
        send_byte(len_word[15:8]);
        repeat (len) send_byte(8'($urandom));
    endtask

    task automatic send_noise_byte();
        logic [7:0] b;
        do b = 8'($urandom); while (b == TYPE_CMD || b == TYPE_ACL);
        send_byte(b);
    endtask

    task automatic send_random_packet();
        int pick;
        int r;
        int lim;
        int len;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            send_noise_byte();
            return;
        end
        if (pick < 15) begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
            return;
        end
        lim = (pick < 57) ? int'(cmd_limit) : int'(acl_limit);
        r = $urandom_range(0, 9);
        if (r == 0) len = 0;
        else if (r == 1) len = lim;
        else if (r == 2) len = lim + 1;
        else len = $urandom_range(1, 16);
        if (len > 300) len = $urandom_range(1, 16);
        if (pick < 57) begin
            if (len > 255) len = 255;
            send_cmd(len);
        end else begin
            send_acl(len);
        end
    endtask

    task automatic random_traffic(input int count);
        int target;
        target = items_sent + count;
        while (items_sent < target) send_random_packet();
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_limits(input logic [7:0] cmd_max, input logic [15:0] acl_max);
        wait_idle();
        apb_write(ADDR_CMD_MAX, {24'h0, cmd_max});
        cmd_limit = cmd_max;
        @(posedge i_clk);
        apb_write(ADDR_ACL_MAX, {16'h0, acl_max});
        acl_limit = acl_max;
    endtask

    task automatic test_special_bytes();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h03);
        send_cmd(0);
        send_cmd(2);
        send_acl(0);
        send_acl(1);
    endtask

    task automatic test_tight_limits();
        set_limits(8'd0, 16'd0);
        send_cmd(1);
        send_acl(3);
        send_cmd(0);
        send_acl(0);
        random_traffic(100);
    endtask

    task automatic test_wide_limits();
        set_limits(8'd255, 16'hFFFF);
        send_cmd(255);
        send_acl(256);
        random_traffic(100);
    endtask

    task automatic test_random_limits();
        repeat (4) begin
            set_limits(8'($urandom_range(0, 32)), 16'($urandom_range(0, 100)));
            random_traffic(100);
        end
    endtask

    task automatic test_default_limits();
        set_limits(CMD_MAX_RESET, ACL_MAX_RESET);
        send_acl(int'(ACL_MAX_RESET) + 1);
        send_acl(int'(ACL_MAX_RESET));
        random_traffic(150);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_special_bytes();
        random_traffic(100);
        test_tight_limits();
        test_wide_limits();
        test_random_limits();
        test_default_limits();
        wait_idle();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/hcih4_pkg.sv
rtl/hcih4_cfg.sv
rtl/hcih4_fsm.sv
rtl/hcih4_out.sv
rtl/hci_h4_uart_deframer_top.sv
tb/tb_hci_h4_uart_deframer_top.sv
